>>> rtl/icrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrd_pkg
// Shared types, constants and register indexes of the crash/rollover detector.
// ----------------------------------------------------------------------------
package icrd_pkg;

	localparam int ACCEL_LSB_PER_G_DEF  = 2048;
	localparam int GYRO_LSB_PER_DPS_DEF = 16;
	localparam int MG_PER_G             = 1000;
	localparam int GYRO_MAX             = 4095;

	localparam logic [1:0] REQ_VALID   = 2'd0;
	localparam logic [1:0] REQ_INVALID = 2'd1;
	localparam logic [1:0] REQ_REMOTE  = 2'd2;
	localparam logic [1:0] REQ_RESTORE = 2'd3;

	localparam logic [1:0] KIND_NONE      = 2'd0;
	localparam logic [1:0] KIND_COLLISION = 2'd1;
	localparam logic [1:0] KIND_ROLLOVER  = 2'd2;

	localparam logic [2:0] REG_COL_THR   = 3'd0;
	localparam logic [2:0] REG_COL_CONF  = 3'd1;
	localparam logic [2:0] REG_ROLL_ZMAX = 3'd2;
	localparam logic [2:0] REG_ROLL_HOR  = 3'd3;
	localparam logic [2:0] REG_INV_Z     = 3'd4;
	localparam logic [2:0] REG_ROLL_CONF = 3'd5;
	localparam logic [2:0] REG_HOLD      = 3'd6;

	// classified item handed from the front end to the event engine
	typedef struct packed {
		logic [1:0]  req;
		logic [31:0] now;
		logic [1:0]  rtype;
		logic [31:0] eid;
		logic [15:0] rpeak_a;
		logic [15:0] rpeak_g;
		logic [13:0] accel;
		logic [11:0] gyro;
		logic        col_hit;
		logic        roll_hit;
	} icrd_item_t;

	typedef struct packed {
		logic        active;
		logic [1:0]  kind;
		logic [31:0] last_id;
		logic [31:0] first_ms;
		logic [15:0] col_total;
		logic [15:0] roll_total;
		logic [15:0] peak_a;
		logic [15:0] peak_g;
		logic [13:0] cur_a;
		logic [11:0] cur_g;
		logic        ok;
		logic        pending;
	} icrd_status_t;

endpackage
`default_nettype wire

>>> rtl/icrd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrd_front
// Two-stage front end: scales axes to mg, forms magnitudes, classifies sample.
// ----------------------------------------------------------------------------
module icrd_front import icrd_pkg::*; #(
	parameter int ACCEL_LSB_PER_G  = ACCEL_LSB_PER_G_DEF,
	parameter int GYRO_LSB_PER_DPS = GYRO_LSB_PER_DPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               advance,
	output logic                    out_valid,
	output icrd_item_t              out_item,
	input  wire logic [1:0]         req_type,
	input  wire logic [31:0]        now_ms,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	input  wire logic [1:0]         remote_event_type,
	input  wire logic [31:0]        event_id,
	input  wire logic [15:0]        remote_peak_accel_mg,
	input  wire logic [15:0]        remote_peak_gyro_dps,
	input  wire logic [13:0]        col_thr,
	input  wire logic [13:0]        roll_zmax,
	input  wire logic [13:0]        roll_hor,
	input  wire logic signed [15:0] inv_z
) ;

	// reciprocal constants: exact floor division for 17-bit magnitudes
	localparam int ACC_SH = 30;
	localparam longint unsigned ACC_K = ((64'(MG_PER_G) << ACC_SH) +
		64'(ACCEL_LSB_PER_G) - 64'd1) / 64'(ACCEL_LSB_PER_G);
	localparam int GYR_SH = 24;
	localparam longint unsigned GYR_K = ((64'd1 << GYR_SH) +
		64'(GYRO_LSB_PER_DPS) - 64'd1) / 64'(GYRO_LSB_PER_DPS);

	function automatic logic [16:0] absv(input logic signed [15:0] v);
		logic signed [16:0] e;
		e = 17'(v);
		return e[16] ? 17'(-e) : e;
	endfunction

	function automatic logic [16:0] mg(input logic [16:0] m);
		logic [48:0] p;
		p = 49'(m) * 49'(ACC_K);
		return 17'(p >> ACC_SH);
	endfunction

	function automatic logic [16:0] dps(input logic [16:0] m);
		logic [41:0] p;
		p = 42'(m) * 42'(GYR_K);
		return 17'(p >> GYR_SH);
	endfunction

	// stage 1: mg per axis, largest gyro axis in dps
	logic              v_s1;
	icrd_item_t        it_s1;
	logic [16:0]       xm_s1, ym_s1, zm_s1;
	logic [16:0]       gm_s1;
	logic              inv_s1;
	logic              v_s2;
	icrd_item_t        it_s2;
	icrd_item_t        it_d1, it_d2;
	logic [16:0]       a, b, c, t1, t2, t3;
	logic [18:0]       mag;
	logic [34:0]       hsq;
	logic [27:0]       hth;
	logic [16:0]       gx, gy, gz, gmax;

	assign gx = dps(absv(gyro_x));
	assign gy = dps(absv(gyro_y));
	assign gz = dps(absv(gyro_z));
	always_comb begin
		gmax = (gx > gy) ? gx : gy;
		if (gz > gmax) gmax = gz;
	end

	always_comb begin
		it_d1         = '0;
		it_d1.req     = req_type;
		it_d1.now     = now_ms;
		it_d1.rtype   = remote_event_type;
		it_d1.eid     = event_id;
		it_d1.rpeak_a = remote_peak_accel_mg;
		it_d1.rpeak_g = remote_peak_gyro_dps;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			it_s1          <= it_d1;
			xm_s1          <= mg(absv(accel_x));
			ym_s1          <= mg(absv(accel_y));
			zm_s1          <= mg(absv(accel_z));
			gm_s1          <= gmax;
			inv_s1         <= (accel_z <= inv_z);
		end
	end

	// stage 2: sort, magnitude, horizontal test
	always_comb begin
		a = xm_s1; b = ym_s1; c = zm_s1;
		if (a < b) begin t1 = a; a = b; b = t1; end else t1 = '0;
		if (a < c) begin t2 = a; a = c; c = t2; end else t2 = '0;
		if (b < c) begin t3 = b; b = c; c = t3; end else t3 = '0;
		mag = 19'(a) + 19'(b >> 1) + 19'(c >> 2);
		hsq = 35'(34'(xm_s1) * 34'(xm_s1)) + 35'(34'(ym_s1) * 34'(ym_s1));
		hth = 28'(roll_hor) * 28'(roll_hor);
	end

	always_comb begin
		it_d2          = it_s1;
		it_d2.accel    = (mag >= 19'(col_thr)) ? col_thr : mag[13:0];
		it_d2.gyro     = (gm_s1 > 17'(GYRO_MAX)) ? 12'(GYRO_MAX) : gm_s1[11:0];
		it_d2.col_hit  = (mag >= 19'(col_thr));
		it_d2.roll_hit = ((zm_s1 <= 17'(roll_zmax)) && (hsq >= 35'(hth))) || inv_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			it_s2 <= it_d2;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = it_s2;

endmodule
`default_nettype wire

>>> rtl/icrd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrd_queue
// Small register FIFO of generic payload width.
// ----------------------------------------------------------------------------
module icrd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule
`default_nettype wire

>>> rtl/icrd_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrd_engine
// Event state: confirm runs, raise, hold expiry, ids and peak tracking.
// ----------------------------------------------------------------------------
module icrd_engine import icrd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire icrd_item_t  item,
	input  wire logic [15:0] col_conf,
	input  wire logic [15:0] roll_conf,
	input  wire logic [31:0] hold_ms,
	output icrd_status_t     status
);

	logic        act_q;
	logic [1:0]  kind_q;
	logic [31:0] hold_q, first_q, next_id_q, last_id_q;
	logic [15:0] peak_a_q, peak_g_q, col_tot_q, roll_tot_q, col_run_q, roll_run_q;
	logic [13:0] cur_a_q;
	logic [11:0] cur_g_q;
	logic        ok_q, pend_q;

	logic        act_n;
	logic [1:0]  kind_n;
	logic [31:0] hold_n, first_n, next_id_n, last_id_n, diff;
	logic [15:0] peak_a_n, peak_g_n, col_tot_n, roll_tot_n, col_run_n, roll_run_n;
	logic [13:0] cur_a_n;
	logic [11:0] cur_g_n;
	logic        ok_n, pend_n;
	logic        col_raise, roll_raise;
	logic [1:0]  rk;

	always_comb begin
		act_n = act_q; kind_n = kind_q; hold_n = hold_q; first_n = first_q;
		next_id_n = next_id_q; last_id_n = last_id_q; peak_a_n = peak_a_q;
		peak_g_n = peak_g_q; col_tot_n = col_tot_q; roll_tot_n = roll_tot_q;
		col_run_n = col_run_q; roll_run_n = roll_run_q; cur_a_n = cur_a_q;
		cur_g_n = cur_g_q; ok_n = ok_q; pend_n = pend_q;
		col_raise = 1'b0; roll_raise = 1'b0;
		diff = item.now - hold_q;
		rk = item.rtype;
		unique case (item.req)
			REQ_VALID, REQ_INVALID: begin
				if (act_q && !diff[31]) begin
					act_n = 1'b0; kind_n = KIND_NONE;
				end
				if (item.req == REQ_INVALID) begin
					ok_n = 1'b0;
				end else begin
					ok_n = 1'b1;
					cur_a_n = item.accel;
					cur_g_n = item.gyro;
					if (item.col_hit) begin
						if (col_run_q < col_conf) col_run_n = col_run_q + 1'b1;
						if (col_run_n >= col_conf) begin
							col_raise = 1'b1; col_run_n = '0;
						end
					end else begin
						col_run_n = '0;
					end
					if (item.roll_hit) begin
						if (roll_run_q < roll_conf) roll_run_n = roll_run_q + 1'b1;
						if (roll_run_n >= roll_conf) begin
							roll_raise = 1'b1; roll_run_n = '0; pend_n = 1'b0;
						end else begin
							pend_n = 1'b1;
						end
					end else begin
						roll_run_n = '0; pend_n = 1'b0;
					end
				end
				// collision first, then rollover
				if (col_raise) begin
					hold_n = item.now + hold_ms;
					if (act_n && kind_n == KIND_COLLISION) begin
						if (16'(item.accel) > peak_a_n) peak_a_n = 16'(item.accel);
						if (16'(item.gyro) > peak_g_n) peak_g_n = 16'(item.gyro);
					end else begin
						act_n = 1'b1; kind_n = KIND_COLLISION; first_n = item.now;
						next_id_n = next_id_n + 1'b1; last_id_n = next_id_n;
						peak_a_n = 16'(item.accel); peak_g_n = 16'(item.gyro);
						col_tot_n = col_tot_n + 1'b1;
					end
				end
				if (roll_raise) begin
					hold_n = item.now + hold_ms;
					if (act_n && kind_n == KIND_ROLLOVER) begin
						if (16'(item.accel) > peak_a_n) peak_a_n = 16'(item.accel);
						if (16'(item.gyro) > peak_g_n) peak_g_n = 16'(item.gyro);
					end else begin
						act_n = 1'b1; kind_n = KIND_ROLLOVER; first_n = item.now;
						next_id_n = next_id_n + 1'b1; last_id_n = next_id_n;
						peak_a_n = 16'(item.accel); peak_g_n = 16'(item.gyro);
						roll_tot_n = roll_tot_n + 1'b1;
					end
				end
			end
			REQ_REMOTE: begin
				if (rk == KIND_COLLISION || rk == KIND_ROLLOVER) begin
					hold_n = item.now + hold_ms;
					if (act_q && kind_q == rk) begin
						if (item.rpeak_a > peak_a_q) peak_a_n = item.rpeak_a;
						if (item.rpeak_g > peak_g_q) peak_g_n = item.rpeak_g;
					end else begin
						act_n = 1'b1; kind_n = rk; first_n = item.now;
						next_id_n = next_id_q + 1'b1;
						peak_a_n = item.rpeak_a; peak_g_n = item.rpeak_g;
						if (rk == KIND_COLLISION) col_tot_n = col_tot_q + 1'b1;
						else roll_tot_n = roll_tot_q + 1'b1;
					end
					last_id_n = item.eid;
					ok_n = 1'b0;
				end
			end
			REQ_RESTORE: begin
				if (item.eid > next_id_q) next_id_n = item.eid;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0; kind_q <= KIND_NONE; hold_q <= '0; first_q <= '0;
			next_id_q <= '0; last_id_q <= '0; peak_a_q <= '0; peak_g_q <= '0;
			col_tot_q <= '0; roll_tot_q <= '0; col_run_q <= '0; roll_run_q <= '0;
			cur_a_q <= '0; cur_g_q <= '0; ok_q <= 1'b0; pend_q <= 1'b0;
		end else if (go) begin
			act_q <= act_n; kind_q <= kind_n; hold_q <= hold_n; first_q <= first_n;
			next_id_q <= next_id_n; last_id_q <= last_id_n; peak_a_q <= peak_a_n;
			peak_g_q <= peak_g_n; col_tot_q <= col_tot_n; roll_tot_q <= roll_tot_n;
			col_run_q <= col_run_n; roll_run_q <= roll_run_n; cur_a_q <= cur_a_n;
			cur_g_q <= cur_g_n; ok_q <= ok_n; pend_q <= pend_n;
		end
	end

	always_comb begin
		status.active     = act_n;
		status.kind       = kind_n;
		status.last_id    = last_id_n;
		status.first_ms   = first_n;
		status.col_total  = col_tot_n;
		status.roll_total = roll_tot_n;
		status.peak_a     = peak_a_n;
		status.peak_g     = peak_g_n;
		status.cur_a      = cur_a_n;
		status.cur_g      = cur_g_n;
		status.ok         = ok_n;
		status.pending    = pend_n;
	end

endmodule
`default_nettype wire

>>> rtl/imu_crash_rollover_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_crash_rollover_detector
// Crash and rollover event detector for raw 6-axis IMU samples.
// ----------------------------------------------------------------------------
// One item is accepted per clock while full is low and yields one status
// snapshot. A two-stage front end scales and classifies each item into a
// five-entry queue; the event engine takes one queued item per cycle when
// the four-entry result queue has room. Full rises while the item queue and
// the last front stage together hold at least three transactions, which
// keeps the item queue from overflowing.
module imu_crash_rollover_detector import icrd_pkg::*; #(
	parameter int ACCEL_LSB_PER_G  = ACCEL_LSB_PER_G_DEF,
	parameter int GYRO_LSB_PER_DPS = GYRO_LSB_PER_DPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         req_type,
	input  wire logic [31:0]        now_ms,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	input  wire logic [1:0]         remote_event_type,
	input  wire logic [31:0]        event_id,
	input  wire logic [15:0]        remote_peak_accel_mg,
	input  wire logic [15:0]        remote_peak_gyro_dps,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    event_active,
	output logic [1:0]              event_kind,
	output logic [31:0]             last_id,
	output logic [31:0]             last_event_ms,
	output logic [15:0]             collision_total,
	output logic [15:0]             rollover_total,
	output logic [15:0]             peak_accel_mg,
	output logic [15:0]             peak_gyro_dps,
	output logic [13:0]             current_accel_mg,
	output logic [11:0]             current_gyro_dps,
	output logic                    imu_ok,
	output logic                    rollover_pending
);

	localparam int QD = 4;
	localparam int IW = $bits(icrd_item_t);
	localparam int SW = $bits(icrd_status_t);

	logic [13:0]        col_thr_q, roll_zmax_q, roll_hor_q;
	logic [15:0]        col_conf_q, roll_conf_q;
	logic signed [15:0] inv_z_q;
	logic [31:0]        hold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_thr_q   <= 14'd6000;
			col_conf_q  <= 16'd1;
			roll_zmax_q <= 14'd500;
			roll_hor_q  <= 14'd750;
			inv_z_q     <= -16'sd1434;
			roll_conf_q <= 16'd500;
			hold_q      <= 32'd10000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COL_THR:   col_thr_q   <= cfg_data[13:0];
				REG_COL_CONF:  col_conf_q  <= cfg_data[15:0];
				REG_ROLL_ZMAX: roll_zmax_q <= cfg_data[13:0];
				REG_ROLL_HOR:  roll_hor_q  <= cfg_data[13:0];
				REG_INV_Z:     inv_z_q     <= cfg_data[15:0];
				REG_ROLL_CONF: roll_conf_q <= cfg_data[15:0];
				REG_HOLD:      hold_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	logic         f_valid, push_ok;
	icrd_item_t   f_item, q_item;
	logic [IW-1:0] q_rdata;
	logic         iq_empty, rq_empty, go;
	logic [$clog2(QD+1)-1:0] iq_cnt, rq_cnt;
	icrd_status_t st;
	logic [SW-1:0] r_rdata;
	icrd_status_t r_st;
	logic [3:0]   in_flight;

	// credit: front stages plus item queue never exceed item queue depth
	assign in_flight = 4'(iq_cnt) + 4'(f_valid) ;
	assign full      = (in_flight >= 4'(QD - 1));
	assign push_ok   = push && !full;

	icrd_front #(
		.ACCEL_LSB_PER_G  (ACCEL_LSB_PER_G),
		.GYRO_LSB_PER_DPS (GYRO_LSB_PER_DPS)
	) u_front (
		.clk, .arst_n,
		.in_valid (push_ok),
		.advance  (1'b1),
		.out_valid(f_valid),
		.out_item (f_item),
		.req_type, .now_ms, .accel_x, .accel_y, .accel_z,
		.gyro_x, .gyro_y, .gyro_z, .remote_event_type, .event_id,
		.remote_peak_accel_mg, .remote_peak_gyro_dps,
		.col_thr  (col_thr_q),
		.roll_zmax(roll_zmax_q),
		.roll_hor (roll_hor_q),
		.inv_z    (inv_z_q)
	);

	icrd_queue #(.WIDTH(IW), .DEPTH(QD+1)) u_iq (
		.clk, .arst_n,
		.wr   (f_valid),
		.wdata(f_item),
		.rd   (go),
		.rdata(q_rdata),
		.empty(iq_empty),
		.count(iq_cnt)
	);
	assign q_item = icrd_item_t'(q_rdata);
	assign go = !iq_empty && (rq_cnt < 3'(QD));

	icrd_engine u_eng (
		.clk, .arst_n,
		.go       (go),
		.item     (q_item),
		.col_conf (col_conf_q),
		.roll_conf(roll_conf_q),
		.hold_ms  (hold_q),
		.status   (st)
	);

	icrd_queue #(.WIDTH(SW), .DEPTH(QD)) u_rq (
		.clk, .arst_n,
		.wr   (go),
		.wdata(st),
		.rd   (pop && !rq_empty),
		.rdata(r_rdata),
		.empty(rq_empty),
		.count(rq_cnt)
	);
	assign r_st  = icrd_status_t'(r_rdata);
	assign empty = rq_empty;

	assign event_active     = r_st.active;
	assign event_kind       = r_st.kind;
	assign last_id          = r_st.last_id;
	assign last_event_ms    = r_st.first_ms;
	assign collision_total  = r_st.col_total;
	assign rollover_total   = r_st.roll_total;
	assign peak_accel_mg    = r_st.peak_a;
	assign peak_gyro_dps    = r_st.peak_g;
	assign current_accel_mg = r_st.cur_a;
	assign current_gyro_dps = r_st.cur_g;
	assign imu_ok           = r_st.ok;
	assign rollover_pending = r_st.pending;

endmodule
`default_nettype wire
